[src/pip_pkg.sv]
// Shared types and constants of the point-in-polygon test block.
// Used by pip_cfg, pip_edge and the top level; depends on nothing else.
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int FIELD_W          = 16;
  localparam int SLOT_W           = 6;
  localparam int COUNT_W          = 7;
  localparam int DATA_W           = 32;
  localparam int REG_ADDR_W       = 5;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_BOX_X_LOW    = 3'd0,
    REG_BOX_X_HIGH   = 3'd1,
    REG_BOX_Y_LOW    = 3'd2,
    REG_BOX_Y_HIGH   = 3'd3,
    REG_VERTEX_COUNT = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] box_x_low;
    logic signed [FIELD_W-1:0] box_x_high;
    logic signed [FIELD_W-1:0] box_y_low;
    logic signed [FIELD_W-1:0] box_y_high;
    logic [COUNT_W-1:0]        vertex_count;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } edge_ctl_t;

  typedef struct packed {
    logic done;
    logic parity;
  } res_t;

endpackage

`default_nettype wire

[src/pip_cfg.sv]
// APB-style register file holding the bounding box and the vertex count.
// Depends on pip_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module pip_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pip_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [pip_pkg::DATA_W-1:0]       pwdata,
  output logic [pip_pkg::DATA_W-1:0]       prdata,
  output logic                             pready,
  output pip_pkg::cfg_t                    cfg
);
  import pip_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[REG_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.box_x_low    <= 16'sh8000;
      cfg_r.box_x_high   <= 16'sh7FFF;
      cfg_r.box_y_low    <= 16'sh8000;
      cfg_r.box_y_high   <= 16'sh7FFF;
      cfg_r.vertex_count <= COUNT_W'(3);
    end else if (wr_en) begin
      unique case (idx)
        REG_BOX_X_LOW:    cfg_r.box_x_low    <= pwdata[FIELD_W-1:0];
        REG_BOX_X_HIGH:   cfg_r.box_x_high   <= pwdata[FIELD_W-1:0];
        REG_BOX_Y_LOW:    cfg_r.box_y_low    <= pwdata[FIELD_W-1:0];
        REG_BOX_Y_HIGH:   cfg_r.box_y_high   <= pwdata[FIELD_W-1:0];
        REG_VERTEX_COUNT: cfg_r.vertex_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BOX_X_LOW:    prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_r.box_x_low};
      REG_BOX_X_HIGH:   prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_r.box_x_high};
      REG_BOX_Y_LOW:    prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_r.box_y_low};
      REG_BOX_Y_HIGH:   prdata = {{(DATA_W-FIELD_W){1'b0}}, cfg_r.box_y_high};
      REG_VERTEX_COUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_r.vertex_count};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[src/pip_vmem.sv]
// Vertex table: one write port and one read port with registered read data.
// Each entry packs a vertex as {x, y}; depends on nothing else.
`default_nettype none

module pip_vmem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/pip_edge.sv]
// Three-stage edge crossing pipeline with the even-odd parity accumulator.
// Depends on pip_pkg for the edge control and result bundles.
`default_nettype none

module pip_edge #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          clear,
  input  pip_pkg::edge_ctl_t            edge_ctl,
  input  logic signed [COORD_WIDTH-1:0] xa,
  input  logic signed [COORD_WIDTH-1:0] ya,
  input  logic signed [COORD_WIDTH-1:0] xb,
  input  logic signed [COORD_WIDTH-1:0] yb,
  input  logic signed [COORD_WIDTH-1:0] px,
  input  logic signed [COORD_WIDTH-1:0] py,
  output pip_pkg::res_t                 res
);
  import pip_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  edge_ctl_t            s1_ctl_r;
  logic                 s1_straddle_r;
  logic signed [DW-1:0] s1_dy_r;
  logic signed [DW-1:0] s1_dpx_r;
  logic signed [DW-1:0] s1_dxb_r;
  logic signed [DW-1:0] s1_dpy_r;

  edge_ctl_t            s2_ctl_r;
  logic                 s2_straddle_r;
  logic                 s2_pos_r;
  logic signed [PW-1:0] s2_lhs_r;
  logic signed [PW-1:0] s2_rhs_r;

  logic                 parity_r;
  logic                 done_r;
  logic                 crossed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
    end else begin
      s1_ctl_r <= edge_ctl;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_straddle_r <= (ya > py) != (yb > py);
    s1_dy_r       <= DW'(yb) - DW'(ya);
    s1_dpx_r      <= DW'(px) - DW'(xa);
    s1_dxb_r      <= DW'(xb) - DW'(xa);
    s1_dpy_r      <= DW'(py) - DW'(ya);
    s2_straddle_r <= s1_straddle_r;
    s2_pos_r      <= !s1_dy_r[DW-1];
    s2_lhs_r      <= PW'(s1_dpx_r) * PW'(s1_dy_r);
    s2_rhs_r      <= PW'(s1_dxb_r) * PW'(s1_dpy_r);
  end

  assign crossed = s2_straddle_r && (s2_pos_r ? (s2_lhs_r < s2_rhs_r) : (s2_lhs_r > s2_rhs_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      parity_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= s2_ctl_r.valid && s2_ctl_r.last;
      if (clear) begin
        parity_r <= 1'b0;
      end else if (s2_ctl_r.valid && crossed) begin
        parity_r <= !parity_r;
      end
    end
  end

  assign res.done   = done_r;
  assign res.parity = parity_r;

endmodule

`default_nettype wire

[src/point_in_polygon_test.sv]
// Point-in-polygon test, top level: sequencer, vertex table and crossing pipeline.
// A query inside the box reads one edge per cycle through the single vertex table read
// port; a query outside the box or with a count of zero skips the table walk.
// The next item is taken when the result leaves the sequencer for the output register.
// Synchronous reset clears the control state and sets the configuration defaults;
// the data registers and the vertex table stay undefined.
`default_nettype none

module point_in_polygon_test #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_cmd,
  input  logic [pip_pkg::SLOT_W-1:0]          in_vertex_slot,
  input  logic signed [pip_pkg::FIELD_W-1:0]  in_coord_x,
  input  logic signed [pip_pkg::FIELD_W-1:0]  in_coord_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_inside_res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pip_pkg::REG_ADDR_W-1:0]      paddr,
  input  logic [pip_pkg::DATA_W-1:0]          pwdata,
  output logic [pip_pkg::DATA_W-1:0]          prdata,
  output logic                                pready
);
  import pip_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int BW   = ((CW > FIELD_W) ? CW : FIELD_W) + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  cfg_t              cfg;
  res_t              res;
  edge_ctl_t         edge_ctl;

  state_t            state_r, state_nxt;
  logic [CNTW-1:0]   iss_r, iss_nxt;
  logic              iss_act_r, iss_act_nxt;
  logic [CNTW-1:0]   n_r, n_nxt;
  logic signed [CW-1:0] px_r, px_nxt;
  logic signed [CW-1:0] py_r, py_nxt;
  logic              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_inside_r, out_inside_nxt;
  logic              clear;

  logic              rd_valid_r, rd_first_r, rd_last_r;
  logic [2*CW-1:0]   prev_r;
  logic [2*CW-1:0]   rdata;

  logic signed [CW-1:0] px_in, py_in;
  logic              in_accept;
  logic              box_miss;
  logic [CNTW-1:0]   n_sat;
  logic [31:0]       slot_wide;
  logic              mem_we;
  logic              issue;
  logic [CNTW-1:0]   raddr_full;

  pip_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  generate
    if (CW <= FIELD_W) begin : g_narrow
      assign px_in = in_coord_x[CW-1:0];
      assign py_in = in_coord_y[CW-1:0];
    end else begin : g_wide
      assign px_in = {{(CW-FIELD_W){1'b0}}, in_coord_x};
      assign py_in = {{(CW-FIELD_W){1'b0}}, in_coord_y};
    end
  endgenerate

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign box_miss = (BW'(px_in) < BW'(cfg.box_x_low))  || (BW'(px_in) > BW'(cfg.box_x_high)) ||
                    (BW'(py_in) < BW'(cfg.box_y_low))  || (BW'(py_in) > BW'(cfg.box_y_high));

  assign n_sat = (32'(cfg.vertex_count) > MAX_VERTICES) ? CNTW'(MAX_VERTICES)
                                                        : CNTW'(cfg.vertex_count);

  assign slot_wide = 32'(in_vertex_slot);
  assign mem_we    = in_accept && (in_cmd == CMD_WRITE) && (slot_wide < MAX_VERTICES);

  assign issue      = (state_r == ST_WALK) && iss_act_r;
  assign raddr_full = (iss_r == '0) ? (n_r - CNTW'(1)) : (iss_r - CNTW'(1));

  pip_vmem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (2 * CW)
  ) u_vmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (slot_wide[AW-1:0]),
    .wdata ({px_in, py_in}),
    .raddr (raddr_full[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
      rd_first_r <= 1'b0;
      rd_last_r  <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      rd_first_r <= issue && (iss_r == '0);
      rd_last_r  <= issue && (iss_r == n_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      prev_r <= rdata;
    end
  end

  assign edge_ctl.valid = rd_valid_r && !rd_first_r;
  assign edge_ctl.last  = rd_last_r;

  pip_edge #(
    .COORD_WIDTH (CW)
  ) u_edge (
    .clk      (clk),
    .rst_n    (rst_n),
    .clear    (clear),
    .edge_ctl (edge_ctl),
    .xa       (prev_r[2*CW-1:CW]),
    .ya       (prev_r[CW-1:0]),
    .xb       (rdata[2*CW-1:CW]),
    .yb       (rdata[CW-1:0]),
    .px       (px_r),
    .py       (py_r),
    .res      (res)
  );

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    iss_act_nxt    = iss_act_r;
    n_nxt          = n_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_inside_nxt = out_inside_r;
    clear          = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && (in_cmd == CMD_QUERY)) begin
          px_nxt = px_in;
          py_nxt = py_in;
          n_nxt  = n_sat;
          if (box_miss || (n_sat == '0)) begin
            res_nxt   = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            iss_nxt     = '0;
            iss_act_nxt = 1'b1;
            clear       = 1'b1;
            state_nxt   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (iss_act_r) begin
          if (iss_r == n_r) begin
            iss_act_nxt = 1'b0;
          end else begin
            iss_nxt = iss_r + CNTW'(1);
          end
        end
        if (res.done) begin
          res_nxt   = res.parity;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_inside_nxt = res_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iss_r       <= '0;
      iss_act_r   <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      iss_act_r   <= iss_act_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    res_r        <= res_nxt;
    out_inside_r <= out_inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_inside_r;

`ifndef SYNTHESIS
  a_done_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (state_r == ST_WALK))
    else $error("edge pipeline finished outside of a walk");

  a_no_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !mem_we)
    else $error("vertex table written during a walk");

  a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (iss_r <= n_r))
    else $error("read counter ran past the vertex count");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_DONE))
    else $error("result transfer started without a finished query");
`endif

endmodule

`default_nettype wire
